>>> sv/pspc_pkg.sv
// ----------------------------------------------------------------------------
// pspc_pkg
// Shared types, codes and command tables for the dust sensor poll controller.
// ----------------------------------------------------------------------------
package pspc_pkg;

	localparam int FRAME_BYTES_DEF = 32;
	localparam int CMD_LEN         = 7;
	localparam int ACK_LEN         = 8;
	localparam int REG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int OUT_DATA_W      = 48;

	// Register defaults
	localparam logic [REG_W-1:0] POLL_PERIOD_RST   = 16'd1000;
	localparam logic [REG_W-1:0] POWER_OFF_RST     = 16'd1000;
	localparam logic [REG_W-1:0] RETRY_WAIT_RST    = 16'd1000;
	localparam logic [REG_W-1:0] ACK_TIMEOUT_RST   = 16'd100;
	localparam logic [REG_W-1:0] FRAME_TIMEOUT_RST = 16'd200;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 3'd4;

	// Phase codes
	localparam logic [2:0] PH_DETECT    = 3'd0;
	localparam logic [2:0] PH_POWER_OFF = 3'd1;
	localparam logic [2:0] PH_ACK       = 3'd2;
	localparam logic [2:0] PH_POLL      = 3'd3;
	localparam logic [2:0] PH_FRAME     = 3'd4;
	localparam logic [2:0] PH_RETRY     = 3'd5;

	// Command selection
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_MODE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Input kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_BYTE = 1'b1;

	// Output kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_TX     = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] poll_period_ms;
		logic [REG_W-1:0] power_off_ms;
		logic [REG_W-1:0] retry_wait_ms;
		logic [REG_W-1:0] ack_timeout_ms;
		logic [REG_W-1:0] frame_timeout_ms;
	} cfg_t;

	// Outcome of one input item: command to send and status after the item
	typedef struct packed {
		logic [1:0]  cmd;
		logic        power;
		logic        fault;
		logic        valid;
		logic [15:0] fine_dust;
		logic [15:0] coarse_dust;
	} step_res_t;

	function automatic logic [7:0] cmd_byte(input logic [1:0] sel, input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h42;
			3'd1:    b = 8'h4d;
			3'd2:    b = (sel == CMD_READ) ? 8'he2 : 8'he1;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h00;
			3'd5:    b = 8'h01;
			3'd6:    b = (sel == CMD_READ) ? 8'h71 : 8'h70;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] ack_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h42;
			3'd1:    b = 8'h4d;
			3'd2:    b = 8'h00;
			3'd3:    b = 8'h04;
			3'd4:    b = 8'he1;
			3'd5:    b = 8'h00;
			3'd6:    b = 8'h01;
			default: b = 8'h74;
		endcase
		return b;
	endfunction

endpackage

>>> sv/particle_sensor_poll_controller_core.sv
// ----------------------------------------------------------------------------
// particle_sensor_poll_controller_core
// Dust sensor controller: power cycle, passive-mode setup, periodic frame read.
// ----------------------------------------------------------------------------
//  channel  direction  signals                       content
//  s_*      in         tvalid tready tdata tuser     tick (tuser 0) or rx byte
//  m_*      out        tvalid tready tdata tuser     tx byte (tuser 1) / status
//                      tlast                          tlast on final result
//  cfg_*    in         valid ready index data        register write
//
// An input item is taken and updates the state at once; its results sit
// in the result register and leave one per cycle while m_tready is high:
// 1 for a status-only item, 8 when a command goes out (7 bytes plus status).
// A new item is taken in the cycle the last result of the previous one leaves.
// Reset restores register defaults and puts the sequencer in its detect phase.
// Stalls on m_tready hold the result register and back up to s_tready.
module particle_sensor_poll_controller_core #(
	parameter int FRAME_BYTES = pspc_pkg::FRAME_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	input  logic                                s_tuser,   // [0] mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] tx_byte, [8] sensor_power, [24:9] fine_dust, [40:25] coarse_dust,
	// [41] fault, [42] valid_res, [47:43] zero
	output logic [pspc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser,   // [0] kind
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pspc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pspc_pkg::REG_W-1:0]          cfg_data
);

	pspc_pkg::cfg_t      cfg_q;
	pspc_pkg::step_res_t res;
	logic                busy, fin, take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy || fin;
	assign take      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period_ms   <= pspc_pkg::POLL_PERIOD_RST;
			cfg_q.power_off_ms     <= pspc_pkg::POWER_OFF_RST;
			cfg_q.retry_wait_ms    <= pspc_pkg::RETRY_WAIT_RST;
			cfg_q.ack_timeout_ms   <= pspc_pkg::ACK_TIMEOUT_RST;
			cfg_q.frame_timeout_ms <= pspc_pkg::FRAME_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pspc_pkg::REG_POLL_PERIOD:   cfg_q.poll_period_ms   <= cfg_data;
				pspc_pkg::REG_POWER_OFF:     cfg_q.power_off_ms     <= cfg_data;
				pspc_pkg::REG_RETRY_WAIT:    cfg_q.retry_wait_ms    <= cfg_data;
				pspc_pkg::REG_ACK_TIMEOUT:   cfg_q.ack_timeout_ms   <= cfg_data;
				pspc_pkg::REG_FRAME_TIMEOUT: cfg_q.frame_timeout_ms <= cfg_data;
				default:                     ;
			endcase
		end
	end

	pspc_seq #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.mode    (s_tuser),
		.rx_byte (s_tdata),
		.cfg     (cfg_q),
		.res     (res)
	);

	pspc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.res      (res),
		.busy     (busy),
		.fin      (fin),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> sv/pspc_seq.sv
// ----------------------------------------------------------------------------
// pspc_seq
// Protocol sequencer: power cycling, acknowledgement check, frame checksum.
// ----------------------------------------------------------------------------
module pspc_seq #(
	parameter int FRAME_BYTES = pspc_pkg::FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  pspc_pkg::cfg_t      cfg,
	output pspc_pkg::step_res_t res
);

	localparam int CNT_W = $clog2(FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] SUM_END   = CNT_W'(FRAME_BYTES - 2);
	localparam logic [CNT_W-1:0] FRAME_END = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] ACK_END   = CNT_W'(pspc_pkg::ACK_LEN);

	logic [2:0]       phase_q, phase_n;
	logic [15:0]      elapsed_q, elapsed_n, el_inc;
	logic [CNT_W-1:0] count_q, count_n, count_inc;
	logic [15:0]      sum_q, sum_n;
	logic [7:0]       check_high_q, check_high_n;
	logic             ack_match_q, ack_match_n;
	logic [15:0]      fine_stage_q, fine_stage_n, coarse_stage_q, coarse_stage_n;
	logic [15:0]      fine_q, fine_n, coarse_q, coarse_n;
	logic             power_q, power_n, fault_q, fault_n, valid_q, valid_n;
	logic [15:0]      limit;
	logic             done;
	logic [1:0]       cmd;

	assign el_inc    = (elapsed_q != 16'hffff) ? elapsed_q + 16'd1 : elapsed_q;
	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		case (phase_q)
			pspc_pkg::PH_POWER_OFF: limit = cfg.power_off_ms;
			pspc_pkg::PH_ACK:       limit = cfg.ack_timeout_ms;
			pspc_pkg::PH_POLL:      limit = cfg.poll_period_ms;
			pspc_pkg::PH_FRAME:     limit = cfg.frame_timeout_ms;
			default:                limit = cfg.retry_wait_ms;
		endcase
	end
	assign done = el_inc >= limit;

	always_comb begin
		phase_n        = phase_q;
		elapsed_n      = elapsed_q;
		count_n        = count_q;
		sum_n          = sum_q;
		check_high_n   = check_high_q;
		ack_match_n    = ack_match_q;
		fine_stage_n   = fine_stage_q;
		coarse_stage_n = coarse_stage_q;
		fine_n         = fine_q;
		coarse_n       = coarse_q;
		power_n        = power_q;
		fault_n        = fault_q;
		valid_n        = valid_q;
		cmd            = pspc_pkg::CMD_NONE;
		if (mode == pspc_pkg::MODE_TICK) begin
			case (phase_q)
				pspc_pkg::PH_DETECT: begin
					power_n   = 1'b0;
					elapsed_n = '0;
					phase_n   = pspc_pkg::PH_POWER_OFF;
				end
				pspc_pkg::PH_POWER_OFF: begin
					elapsed_n = el_inc;
					if (done) begin
						power_n     = 1'b1;
						cmd         = pspc_pkg::CMD_MODE;
						elapsed_n   = '0;
						count_n     = '0;
						ack_match_n = 1'b1;
						phase_n     = pspc_pkg::PH_ACK;
					end
				end
				pspc_pkg::PH_ACK, pspc_pkg::PH_FRAME: begin
					elapsed_n = el_inc;
					if (done) begin
						fault_n   = 1'b1;
						valid_n   = 1'b0;
						elapsed_n = '0;
						phase_n   = pspc_pkg::PH_RETRY;
					end
				end
				pspc_pkg::PH_POLL: begin
					elapsed_n = el_inc;
					if (done) begin
						cmd       = pspc_pkg::CMD_READ;
						elapsed_n = '0;
						count_n   = '0;
						sum_n     = '0;
						phase_n   = pspc_pkg::PH_FRAME;
					end
				end
				pspc_pkg::PH_RETRY: begin
					elapsed_n = el_inc;
					if (done)
						phase_n = pspc_pkg::PH_DETECT;
				end
				default: phase_n = pspc_pkg::PH_DETECT;
			endcase
		end else if (phase_q == pspc_pkg::PH_ACK) begin
			if (rx_byte != pspc_pkg::ack_byte(count_q[2:0]))
				ack_match_n = 1'b0;
			count_n = count_inc;
			if (count_inc >= ACK_END) begin
				elapsed_n = '0;
				if (ack_match_n) begin
					fault_n = 1'b0;
					phase_n = pspc_pkg::PH_POLL;
				end else begin
					fault_n = 1'b1;
					valid_n = 1'b0;
					phase_n = pspc_pkg::PH_RETRY;
				end
			end
		end else if (phase_q == pspc_pkg::PH_FRAME) begin
			if (count_q < SUM_END)
				sum_n = sum_q + {8'h00, rx_byte};
			case (count_q)
				CNT_W'(6): fine_stage_n   = {rx_byte, fine_stage_q[7:0]};
				CNT_W'(7): fine_stage_n   = {fine_stage_q[15:8], rx_byte};
				CNT_W'(8): coarse_stage_n = {rx_byte, coarse_stage_q[7:0]};
				CNT_W'(9): coarse_stage_n = {coarse_stage_q[15:8], rx_byte};
				SUM_END:   check_high_n   = rx_byte;
				default:   ;
			endcase
			count_n = count_inc;
			if (count_q >= FRAME_END) begin
				elapsed_n = '0;
				if (sum_q == {check_high_q, rx_byte}) begin
					fine_n   = fine_stage_q;
					coarse_n = coarse_stage_q;
					valid_n  = 1'b1;
					phase_n  = pspc_pkg::PH_POLL;
				end else begin
					fault_n = 1'b1;
					valid_n = 1'b0;
					phase_n = pspc_pkg::PH_RETRY;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= pspc_pkg::PH_DETECT;
			elapsed_q      <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			check_high_q   <= '0;
			ack_match_q    <= 1'b1;
			fine_stage_q   <= '0;
			coarse_stage_q <= '0;
			fine_q         <= '0;
			coarse_q       <= '0;
			power_q        <= 1'b0;
			fault_q        <= 1'b0;
			valid_q        <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_n;
			elapsed_q      <= elapsed_n;
			count_q        <= count_n;
			sum_q          <= sum_n;
			check_high_q   <= check_high_n;
			ack_match_q    <= ack_match_n;
			fine_stage_q   <= fine_stage_n;
			coarse_stage_q <= coarse_stage_n;
			fine_q         <= fine_n;
			coarse_q       <= coarse_n;
			power_q        <= power_n;
			fault_q        <= fault_n;
			valid_q        <= valid_n;
		end
	end

	assign res.cmd         = cmd;
	assign res.power       = power_n;
	assign res.fault       = fault_n;
	assign res.valid       = valid_n;
	assign res.fine_dust   = fine_n;
	assign res.coarse_dust = coarse_n;

	// A good frame only ever lands from the frame phase and leaves polling next
	assert property (@(posedge clk) disable iff (!arst_n)
		step && !valid_q && valid_n |-> phase_q == pspc_pkg::PH_FRAME)
		else $error("valid set outside frame phase");
	// Fault and valid are never both set
	assert property (@(posedge clk) disable iff (!arst_n) !(fault_q && valid_q))
		else $error("fault and valid both set");
	// Commands only go out with power on
	assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd != pspc_pkg::CMD_NONE |-> power_n)
		else $error("command sent with power off");

endmodule

>>> sv/pspc_emit.sv
// ----------------------------------------------------------------------------
// pspc_emit
// Result register: plays out command bytes and the closing status report.
// ----------------------------------------------------------------------------
module pspc_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  pspc_pkg::step_res_t               res,
	output logic                              busy,
	output logic                              fin,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pspc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	logic                busy_q;
	logic [2:0]          idx_q;
	pspc_pkg::step_res_t res_q;
	logic                is_tx;
	logic [7:0]          tx_byte;

	assign is_tx   = (res_q.cmd != pspc_pkg::CMD_NONE)
		&& (idx_q < 3'(pspc_pkg::CMD_LEN));
	assign tx_byte = is_tx ? pspc_pkg::cmd_byte(res_q.cmd, idx_q) : 8'h00;

	assign busy     = busy_q;
	assign m_tvalid = busy_q;
	assign m_tlast  = !is_tx;
	assign m_tuser  = is_tx ? pspc_pkg::KIND_TX : pspc_pkg::KIND_STATUS;
	assign m_tdata  = {5'b0, res_q.valid, res_q.fault, res_q.coarse_dust,
		res_q.fine_dust, res_q.power, tx_byte};
	// last transaction of the burst is taken this cycle
	assign fin      = busy_q && m_tready && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (m_tlast)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	// Only a command burst walks past the first result
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && idx_q != 3'd0 |-> res_q.cmd != pspc_pkg::CMD_NONE)
		else $error("index advanced without a command");
	// A stalled result keeps its position
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !m_tready |=> busy_q && $stable(idx_q))
		else $error("result moved while stalled");
	// Loading only happens when the register is free or drains this cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q || fin)
		else $error("result register overwritten");

endmodule
